// ===== sv/pcr_pkg.sv =====
package pcr_pkg;

  localparam int unsigned QOne = 65536;
  localparam int unsigned SqrtSteps = 16;
  localparam int unsigned DivSteps = 16;

  localparam int unsigned StSum = 1;
  localparam int unsigned StSqrt0 = 2;
  localparam int unsigned StDelta = StSqrt0 + SqrtSteps;
  localparam int unsigned StProd = StDelta + 1;
  localparam int unsigned StDiv0 = StProd + 1;
  localparam int unsigned StFinal = StDiv0 + DivSteps;
  localparam int unsigned NumStages = StFinal + 1;

  localparam logic [0:0] RegGain = 1'b0;
  localparam logic [0:0] RegMinDist = 1'b1;
  localparam logic [16:0] GainReset = 17'd65536;
  localparam logic [15:0] MinDistReset = 16'd7;

  typedef struct packed {
    logic [31:0] ax;
    logic [31:0] ay;
    logic [31:0] bx;
    logic [31:0] by;
    logic        sx;
    logic        sy;
    logic [15:0] mx;
    logic [15:0] my;
    logic        near;
    logic        hit;
    logic [31:0] acc;
    logic [18:0] rem;
    logic [15:0] root;
    logic [15:0] delta;
    logic [16:0] rx;
    logic [16:0] ry;
    logic [31:0] px;
    logic [31:0] py;
    logic [15:0] qx;
    logic [15:0] qy;
  } item_t;

  function automatic logic [31:0] sat_add(logic [31:0] a, logic sgn, logic [15:0] q);
    logic signed [33:0] s;
    logic signed [33:0] c;
    c = {18'd0, q};
    if (sgn) c = -c;
    s = $signed({{2{a[31]}}, a}) + c;
    if (s > 34'sd2147483647) return 32'h7fffffff;
    if (s < -34'sd2147483648) return 32'h80000000;
    return s[31:0];
  endfunction

endpackage

// ===== sv/particle_pair_contact_resolve_unit.sv =====
// Contact resolve for one pair of unit-diameter particles, Q16.16 centres.
// One pair enters per clock while in_stall is low; each result passes through the
// stages (offset, squared distance, 16 one-digit square-root stages, gain
// multiply, offset multiply, 16 one-bit divider stages, saturating update).
// An output skid register holds a stalled result; in_stall rises only while
// it is occupied. cfg_ready is always high; write configuration while idle.
module particle_pair_contact_resolve_unit import pcr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [16:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] first_x,
  input  logic [31:0] first_y,
  input  logic [31:0] second_x,
  input  logic [31:0] second_y,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] new_first_x,
  output logic [31:0] new_first_y,
  output logic [31:0] new_second_x,
  output logic [31:0] new_second_y,
  output logic        in_contact
);

  logic [16:0] response_gain;
  logic [15:0] min_distance_squared;

  item_t st [NumStages];
  item_t nxt [NumStages];
  logic  vld [NumStages];
  item_t sk;
  logic  sk_v;
  logic  en;

  assign cfg_ready = 1'b1;
  assign en = !sk_v;
  assign in_stall = sk_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      response_gain <= GainReset;
      min_distance_squared <= MinDistReset;
    end else if (cfg_valid && cfg_index[7:1] == 7'd0) begin
      if (cfg_index[0] == RegGain) response_gain <= cfg_data;
      if (cfg_index[0] == RegMinDist) min_distance_squared <= cfg_data[15:0];
    end
  end

  // offset and far-apart test
  always_comb begin
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic [32:0] ux;
    logic [32:0] uy;
    nxt[0] = '0;
    dx = $signed({first_x[31], first_x}) - $signed({second_x[31], second_x});
    dy = $signed({first_y[31], first_y}) - $signed({second_y[31], second_y});
    ux = dx[32] ? -dx : dx;
    uy = dy[32] ? -dy : dy;
    nxt[0].ax = first_x;
    nxt[0].ay = first_y;
    nxt[0].bx = second_x;
    nxt[0].by = second_y;
    nxt[0].sx = dx[32];
    nxt[0].sy = dy[32];
    nxt[0].mx = ux[15:0];
    nxt[0].my = uy[15:0];
    nxt[0].near = (ux[32:16] == 17'd0) && (uy[32:16] == 17'd0);
  end

  // squared distance and band test
  always_comb begin
    logic [32:0] sum;
    nxt[StSum] = st[StSum-1];
    sum = ({17'd0, st[StSum-1].mx} * {17'd0, st[StSum-1].mx})
        + ({17'd0, st[StSum-1].my} * {17'd0, st[StSum-1].my});
    nxt[StSum].acc = sum[31:0];
    nxt[StSum].rem = '0;
    nxt[StSum].root = '0;
    nxt[StSum].hit = st[StSum-1].near && !sum[32]
                   && (sum[31:16] > min_distance_squared);
  end

  // square root, one digit per stage
  for (genvar k = StSqrt0; k < StDelta; k++) begin : g_sqrt
    always_comb begin
      logic [18:0] r;
      logic [18:0] trial;
      nxt[k] = st[k-1];
      r = {st[k-1].rem[16:0], st[k-1].acc[31:30]};
      trial = {1'b0, st[k-1].root, 2'b01};
      nxt[k].acc = {st[k-1].acc[29:0], 2'b00};
      if (r >= trial) begin
        nxt[k].rem = r - trial;
        nxt[k].root = {st[k-1].root[14:0], 1'b1};
      end else begin
        nxt[k].rem = r;
        nxt[k].root = {st[k-1].root[14:0], 1'b0};
      end
    end
  end

  always_comb begin
    logic [33:0] p;
    nxt[StDelta] = st[StDelta-1];
    p = response_gain * (17'(QOne) - {1'b0, st[StDelta-1].root});
    nxt[StDelta].delta = p[32:17];
  end

  always_comb begin
    logic [31:0] px;
    logic [31:0] py;
    nxt[StProd] = st[StProd-1];
    px = st[StProd-1].mx * st[StProd-1].delta;
    py = st[StProd-1].my * st[StProd-1].delta;
    nxt[StProd].rx = {1'b0, px[31:16]};
    nxt[StProd].ry = {1'b0, py[31:16]};
    nxt[StProd].px = {px[15:0], 16'd0};
    nxt[StProd].py = {py[15:0], 16'd0};
    nxt[StProd].qx = '0;
    nxt[StProd].qy = '0;
  end

  // divide by dist, one quotient bit per stage
  for (genvar k = StDiv0; k < StFinal; k++) begin : g_div
    always_comb begin
      logic [16:0] r_x;
      logic [16:0] r_y;
      logic [16:0] d;
      nxt[k] = st[k-1];
      d = {1'b0, st[k-1].root};
      r_x = {st[k-1].rx[15:0], st[k-1].px[31]};
      r_y = {st[k-1].ry[15:0], st[k-1].py[31]};
      nxt[k].px = {st[k-1].px[30:0], 1'b0};
      nxt[k].py = {st[k-1].py[30:0], 1'b0};
      nxt[k].rx = (r_x >= d) ? r_x - d : r_x;
      nxt[k].ry = (r_y >= d) ? r_y - d : r_y;
      nxt[k].qx = {st[k-1].qx[14:0], r_x >= d};
      nxt[k].qy = {st[k-1].qy[14:0], r_y >= d};
    end
  end

  always_comb begin
    nxt[StFinal] = st[StFinal-1];
    if (st[StFinal-1].hit) begin
      nxt[StFinal].ax = sat_add(st[StFinal-1].ax, st[StFinal-1].sx, st[StFinal-1].qx);
      nxt[StFinal].ay = sat_add(st[StFinal-1].ay, st[StFinal-1].sy, st[StFinal-1].qy);
      nxt[StFinal].bx = sat_add(st[StFinal-1].bx, !st[StFinal-1].sx, st[StFinal-1].qx);
      nxt[StFinal].by = sat_add(st[StFinal-1].by, !st[StFinal-1].sy, st[StFinal-1].qy);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NumStages; k++) st[k] <= nxt[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NumStages; k++) vld[k] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int k = 1; k < NumStages; k++) vld[k] <= vld[k-1];
    end
  end

  // skid catches the last stage when the sink stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      sk_v <= 1'b0;
    end else if (sk_v) begin
      if (!out_stall) sk_v <= 1'b0;
    end else if (vld[NumStages-1] && out_stall) begin
      sk_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!sk_v) sk <= st[NumStages-1];
  end

  always_comb begin
    item_t o;
    o = sk_v ? sk : st[NumStages-1];
    out_valid = sk_v || vld[NumStages-1];
    new_first_x = o.ax;
    new_first_y = o.ay;
    new_second_x = o.bx;
    new_second_y = o.by;
    in_contact = o.hit;
  end

endmodule

// ===== sv/pcr_checker.sv =====
module pcr_checker import pcr_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] new_first_x,
  input logic        in_contact
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(new_first_x) && $stable(in_contact))
    else $error("stalled output word changed");

  a_reset_idle: assert property (@(posedge clk) $fell(rst) |-> !out_valid && !in_stall)
    else $error("output valid right after reset");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(in_stall) |-> $past(out_valid && out_stall))
    else $error("input stalled without an output stall");

  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no pending output word");

endmodule

bind particle_pair_contact_resolve_unit pcr_checker u_pcr_checker (
  .clk(clk),
  .rst(rst),
  .in_stall(in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .new_first_x(new_first_x),
  .in_contact(in_contact)
);

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import pcr_pkg::*;

  typedef struct packed {
    logic [31:0] fx;
    logic [31:0] fy;
    logic [31:0] sx;
    logic [31:0] sy;
    logic        hit;
  } pair_word_t;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned Latency = 40;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = '0;
  logic [16:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] first_x = '0;
  logic [31:0] first_y = '0;
  logic [31:0] second_x = '0;
  logic [31:0] second_y = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] new_first_x;
  logic [31:0] new_first_y;
  logic [31:0] new_second_x;
  logic [31:0] new_second_y;
  logic        in_contact;

  logic [16:0] gain_q;
  logic [15:0] eps_q;
  pair_word_t  pushed_q[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned sent = 0;
  int unsigned contacts = 0;
  bit          no_idle = 1'b0;

  particle_pair_contact_resolve_unit u_dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic longint push_comp(longint a, longint dl, longint span);
    longint m;
    m = (a < 0) ? -a : a;
    m = (m * dl) / span;
    return (a < 0) ? -m : m;
  endfunction

  function automatic pair_word_t resolve_pair(logic [31:0] fx, logic [31:0] fy,
                                              logic [31:0] sx, logic [31:0] sy);
    pair_word_t r;
    longint ax, ay, bx, by, dx, dy, sum, dis2, span, dl, cx, cy;
    ax = longint'($signed(fx));
    ay = longint'($signed(fy));
    bx = longint'($signed(sx));
    by = longint'($signed(sy));
    dx = ax - bx;
    dy = ay - by;
    r = '{fx, fy, sx, sy, 1'b0};
    if (dx > -65536 && dx < 65536 && dy > -65536 && dy < 65536) begin
      sum = dx * dx + dy * dy;
      dis2 = sum >>> 16;
      if (dis2 < 65536 && dis2 > longint'(eps_q)) begin
        span = longint'(int_sqrt(sum));
        dl = (longint'(gain_q) * (65536 - span)) >>> 17;
        cx = push_comp(dx, dl, span);
        cy = push_comp(dy, dl, span);
        r = '{clamp32(ax + cx), clamp32(ay + cy), clamp32(bx - cx),
              clamp32(by - cy), 1'b1};
      end
    end
    return r;
  endfunction

  // result checker and receiver stall
  always @(posedge clk) begin
    pair_word_t e;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (pushed_q.size() == 0) begin
          $error("result word with nothing expected");
          errors = errors + 1;
        end else begin
          e = pushed_q.pop_front();
          if (new_first_x !== e.fx) begin
            $error("new_first_x exp %h got %h", e.fx, new_first_x); errors = errors + 1;
          end
          if (new_first_y !== e.fy) begin
            $error("new_first_y exp %h got %h", e.fy, new_first_y); errors = errors + 1;
          end
          if (new_second_x !== e.sx) begin
            $error("new_second_x exp %h got %h", e.sx, new_second_x); errors = errors + 1;
          end
          if (new_second_y !== e.sy) begin
            $error("new_second_y exp %h got %h", e.sy, new_second_y); errors = errors + 1;
          end
          if (in_contact !== e.hit) begin
            $error("in_contact exp %b got %b", e.hit, in_contact); errors = errors + 1;
          end
          if (e.hit) contacts <= contacts + 1;
        end
      end
      out_stall <= no_idle ? 1'b0 : ($urandom_range(99) < 28);
    end
  end

  task automatic send_pair(logic [31:0] fx, logic [31:0] fy,
                           logic [31:0] sx, logic [31:0] sy);
    while (!no_idle && $urandom_range(99) < 28) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    first_x <= fx;
    first_y <= fy;
    second_x <= sx;
    second_y <= sy;
    in_valid <= 1'b1;
    pushed_q.insert(pushed_q.size(), resolve_pair(fx, fy, sx, sy));
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic write_reg(logic [7:0] idx, logic [16:0] val);
    in_valid <= 1'b0;
    while (pushed_q.size() != 0) @(posedge clk);
    repeat (Latency) @(posedge clk);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == 8'(RegGain)) gain_q = val;
    else if (idx == 8'(RegMinDist)) eps_q = val[15:0];
  endtask

  // pair near contact: random base, offset within about one unit
  task automatic send_near();
    logic [31:0] bx, by;
    int ox, oy;
    bx = $urandom;
    by = $urandom;
    if ($urandom_range(3) == 0) begin
      bx = {1'b0, {31{1'b1}}} - $urandom_range(40000);
    end
    ox = $urandom_range(131070) - 65535;
    oy = $urandom_range(131070) - 65535;
    if ($urandom_range(3) == 0) begin
      ox = ox / 8;
      oy = oy / 8;
    end
    send_pair(bx + 32'(ox), by + 32'(oy), bx, by);
  endtask

  task automatic test_directed();
    send_pair(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
    send_pair(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
    send_pair('0, '0, '0, '0);
    send_pair(32'h0001_0000, '0, '0, '0);
    send_pair(32'h0000_ffff, '0, '0, '0);
    send_pair('0, 32'hffff_0001, '0, '0);
    send_pair(32'h0000_b504, 32'h0000_b505, '0, '0);
    send_pair(32'h0000_0800, '0, '0, '0);
    send_pair(32'h0000_0300, '0, '0, '0);
    send_pair(32'h0000_02a0, '0, '0, '0);
    send_pair(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_8000, 32'h7fff_8000);
    send_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_8000, 32'h8000_4000);
    send_pair(32'hffff_ffff, 32'hffff_ffff, 32'h0000_4000, 32'h0000_2000);
    send_pair(32'h1234_5678, 32'hdead_beef, 32'h1234_0000, 32'hdeae_0000);
  endtask

  task automatic test_gain_extremes();
    write_reg(8'(RegGain), 17'd0);
    write_reg(8'(RegMinDist), 16'd0);
    repeat (8) send_near();
    send_pair(32'h0000_0100, '0, '0, '0);
    write_reg(8'(RegGain), 17'h1ffff);
    write_reg(8'(RegMinDist), 16'hffff);
    repeat (8) send_near();
    write_reg(8'(RegMinDist), 16'd7);
    send_pair(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_c000, 32'h7fff_c000);
    repeat (6) send_near();
    write_reg(8'd5, 17'h1234);
  endtask

  task automatic test_random(int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      if (i % 300 == 0) begin
        write_reg(8'(RegGain), 17'($urandom_range(131071)));
        write_reg(8'(RegMinDist), 16'($urandom_range(3) == 0 ? $urandom : $urandom_range(64)));
      end
      no_idle = (i >= n / 2 && i < n / 2 + 150);
      if ($urandom_range(9) < 8) send_near();
      else send_pair($urandom, $urandom, $urandom, $urandom);
    end
    no_idle = 1'b0;
  endtask

  initial begin
    gain_q = GainReset;
    eps_q = MinDistReset;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_gain_extremes();
    test_random(1150);
    in_valid <= 1'b0;
    while (pushed_q.size() != 0) @(posedge clk);
    repeat (Latency) @(posedge clk);
    $display("%0d pairs sent, %0d contacts resolved, gain and epsilon swept", sent, contacts);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
